// ===== hdl/rde_pkg.sv =====
// Shared constants, widths and the sequencer state type of the row distance engine.
// No dependencies; compiled first.
package rde_pkg;

   localparam int MAX_ROWS   = 64;
   localparam int MAX_COLS   = 16;
   localparam int VALUE_BITS = 16;

   // field widths fixed by the interface
   localparam int ROW_W   = 6;
   localparam int COL_W   = 4;
   localparam int DIST_W  = 22;
   localparam int ROWS_W  = 7;
   localparam int COLS_W  = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   // store address is {row, col}: row count and column count are powers of two
   localparam int ADDR_W = $clog2(MAX_ROWS * MAX_COLS);

   // datapath widths
   localparam int DIFF_W = VALUE_BITS + 1;
   localparam int ABS_W  = VALUE_BITS;
   localparam int SQ_W   = 2 * ABS_W;
   localparam int SUM_W  = SQ_W + $clog2(MAX_COLS);

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_METRIC = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS   = 2'd2;

   // metric codes
   localparam logic METRIC_MANHATTAN = 1'b0;
   localparam logic METRIC_EUCLIDEAN = 1'b1;

   // input modes
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DIFF,
      ST_MUL,
      ST_ACC,
      ST_ROOT,
      ST_OUT
   } state_type;

endpackage

// ===== hdl/rde_if.sv =====
// Valid/ready channel interfaces of the row distance engine: request, response, csr write.
// Depends on rde_pkg.
interface rde_req_if;
   import rde_pkg::*;
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic        [ROW_W-1:0]      row_index;
   logic        [COL_W-1:0]      col_index;
   logic signed [VALUE_BITS-1:0] value;

   modport source (output valid, mode, row_index, col_index, value, input ready);
   modport sink   (input valid, mode, row_index, col_index, value, output ready);
endinterface

interface rde_rsp_if;
   import rde_pkg::*;
   logic              valid;
   logic              ready;
   logic [ROW_W-1:0]  row_number;
   logic [DIST_W-1:0] distance;
   logic              last;

   modport source (output valid, row_number, distance, last, input ready);
   modport sink   (input valid, row_number, distance, last, output ready);
endinterface

interface rde_csr_if;
   import rde_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/row_distance_engine_top.sv =====
// Row distance engine top level: training store, query buffer, sequencer and shared datapath.
// Depends on rde_pkg and the channel interfaces in rde_if.sv.
//
// Usage:
//   req_ch  : one element per beat. mode 0 writes value into the training store at
//             (row_index, col_index); mode 1 writes the query buffer at col_index.
//             A query beat on column cols_in_use-1 starts a search.
//   rsp_ch  : one beat per stored row 0 .. rows_in_use-1, in row order, with the
//             row number, the distance (Q14.8) and last on the final row.
//   csr_ch  : register writes (metric, rows_in_use, cols_in_use), always ready;
//             write only while the engine is idle.
// Timing: a search holds req_ch.ready low until the last response beat is taken. Each
//   row reads, takes the difference and accumulates per column, then outputs; euclidean
//   mode adds a multiply per column and a bit-serial square root before the output.
//   The store has one registered read port and one adder/multiplier pair serves every
//   column.
// Reset: returns to idle and restores the register defaults; store and query
//   buffer contents are not cleared and must be written before use.
// Stall: a response beat holds in the output register while rsp_ch.ready is low;
//   the sequencer waits there.
module row_distance_engine_top (
   input  logic      clock,
   input  logic      reset,
   rde_req_if.sink   req_ch,
   rde_rsp_if.source rsp_ch,
   rde_csr_if.sink   csr_ch
);
   import rde_pkg::*;

   // configuration
   logic              metric_ff;
   logic [ROWS_W-1:0] rows_ff;
   logic [COLS_W-1:0] cols_ff;
   logic [ROWS_W-1:0] rows_eff;
   logic [COLS_W-1:0] cols_eff;

   // storage
   logic [VALUE_BITS-1:0] store_mem [MAX_ROWS*MAX_COLS];
   logic [VALUE_BITS-1:0] rd_data_ff;
   logic [VALUE_BITS-1:0] qbuf_ff [MAX_COLS];

   // sequencer and datapath
   state_type         state_ff, state_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ABS_W-1:0]  abs_ff, abs_in;
   logic [SQ_W-1:0]   sq_ff, sq_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  res_ff, res_in;
   logic [SUM_W-1:0]  bit_ff, bit_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              req_beat;
   logic              rsp_beat;
   logic              start;
   logic              last_col;
   logic              last_row;
   logic [DIFF_W-1:0] diff;
   logic [SUM_W-1:0]  addend;
   logic [SUM_W-1:0]  trial;

   function automatic logic [DIST_W-1:0] sat_dist(input logic [SUM_W-1:0] v);
      if (v > SUM_W'(DIST_MAX)) begin
         return DIST_MAX;
      end
      return v[DIST_W-1:0];
   endfunction

   // registers clamp to their legal ranges when used
   always_comb begin
      if (rows_ff == '0) begin
         rows_eff = ROWS_W'(1);
      end else if (rows_ff > ROWS_W'(MAX_ROWS)) begin
         rows_eff = ROWS_W'(MAX_ROWS);
      end else begin
         rows_eff = rows_ff;
      end
      if (cols_ff == '0) begin
         cols_eff = COLS_W'(1);
      end else if (cols_ff > COLS_W'(MAX_COLS)) begin
         cols_eff = COLS_W'(MAX_COLS);
      end else begin
         cols_eff = cols_ff;
      end
   end

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign csr_ch.ready     = 1'b1;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.row_number = rsp_row_ff;
   assign rsp_ch.distance  = rsp_dist_ff;
   assign rsp_ch.last      = rsp_last_ff;

   assign req_beat = req_ch.valid && req_ch.ready;
   assign rsp_beat = rsp_valid_ff && rsp_ch.ready;
   assign start    = req_beat && (req_ch.mode == MODE_QUERY)
                     && ({1'b0, req_ch.col_index} == cols_eff - COLS_W'(1));
   assign last_col = ({1'b0, col_ff} == cols_eff - COLS_W'(1));
   assign last_row = ({1'b0, row_ff} == rows_eff - ROWS_W'(1));

   // query - training as a 17-bit signed difference
   assign diff   = {qbuf_ff[col_ff][VALUE_BITS-1], qbuf_ff[col_ff]}
                   - {rd_data_ff[VALUE_BITS-1], rd_data_ff};
   assign addend = (metric_ff == METRIC_EUCLIDEAN) ? SUM_W'(sq_ff) : SUM_W'(abs_ff);
   assign trial  = res_ff + bit_ff;

   // configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         metric_ff <= METRIC_MANHATTAN;
         rows_ff   <= ROWS_W'(64);
         cols_ff   <= COLS_W'(16);
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            CSR_METRIC: metric_ff <= csr_ch.data[0];
            CSR_ROWS:   rows_ff   <= csr_ch.data[ROWS_W-1:0];
            CSR_COLS:   cols_ff   <= csr_ch.data[COLS_W-1:0];
            default:    ;
         endcase
      end
   end

   // training store: one write port, one registered read port at {row, col}
   always_ff @(posedge clock) begin
      if (req_beat && (req_ch.mode == MODE_LOAD)) begin
         store_mem[{req_ch.row_index, req_ch.col_index}] <= req_ch.value;
      end
      rd_data_ff <= store_mem[{row_ff, col_ff}];
   end

   always_ff @(posedge clock) begin
      if (req_beat && (req_ch.mode == MODE_QUERY)) begin
         qbuf_ff[req_ch.col_index] <= req_ch.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff      <= row_in;
      col_ff      <= col_in;
      abs_ff      <= abs_in;
      sq_ff       <= sq_in;
      sum_ff      <= sum_in;
      rem_ff      <= rem_in;
      res_ff      <= res_in;
      bit_ff      <= bit_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      abs_in       = abs_ff;
      sq_in        = sq_ff;
      sum_in       = sum_ff;
      rem_in       = rem_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               row_in   = '0;
               col_in   = '0;
               sum_in   = '0;
               state_in = ST_READ;
            end
         end
         // store address settles; read data lands in rd_data_ff
         ST_READ: begin
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            abs_in   = diff[DIFF_W-1] ? ABS_W'(~diff + DIFF_W'(1)) : ABS_W'(diff);
            state_in = (metric_ff == METRIC_EUCLIDEAN) ? ST_MUL : ST_ACC;
         end
         ST_MUL: begin
            sq_in    = SQ_W'(abs_ff) * SQ_W'(abs_ff);
            state_in = ST_ACC;
         end
         // at most MAX_COLS terms: SUM_W cannot overflow
         ST_ACC: begin
            sum_in = sum_ff + addend;
            if (!last_col) begin
               col_in   = col_ff + COL_W'(1);
               state_in = ST_READ;
            end else if (metric_ff == METRIC_EUCLIDEAN) begin
               rem_in   = sum_in;
               res_in   = '0;
               bit_in   = SUM_W'(1) << (SUM_W - 2);
               state_in = ST_ROOT;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = row_ff;
               rsp_dist_in  = sat_dist(sum_in);
               rsp_last_in  = last_row;
               state_in     = ST_OUT;
            end
         end
         // one result bit per cycle, digit-by-digit square root
         ST_ROOT: begin
            if (rem_ff >= trial) begin
               rem_in = rem_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff == SUM_W'(1)) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = row_ff;
               rsp_dist_in  = sat_dist(res_in);
               rsp_last_in  = last_row;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_beat) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  row_in   = row_ff + ROW_W'(1);
                  col_in   = '0;
                  sum_in   = '0;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

endmodule

// ===== hdl/rde_checker.sv =====
// Port-level checker for the row distance engine and its bind to the top level.
// Depends on rde_pkg and row_distance_engine_top.
module rde_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [rde_pkg::ROW_W-1:0]  rsp_row_number,
   input logic [rde_pkg::DIST_W-1:0] rsp_distance,
   input logic                       rsp_last
);
   import rde_pkg::*;

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row_number)
                                  && $stable(rsp_distance) && $stable(rsp_last))
      else $error("response beat changed while stalled");

   // no new request while a result is pending
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready while response pending");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // more rows follow a non-final beat
   a_more_rows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> !req_ready)
      else $error("engine went idle before final row");

   a_back_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready && !rsp_valid)
      else $error("engine not idle after final row");

endmodule

bind row_distance_engine_top rde_checker u_rde_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_row_number (rsp_ch.row_number),
   .rsp_distance   (rsp_ch.distance),
   .rsp_last       (rsp_ch.last)
);

// ===== test/row_distance_engine_top_tb.sv =====
// Self-checking testbench for row_distance_engine_top: loads training rows, sends queries and
// checks every row distance against a predictor kept inside the bench.
// Depends on rde_pkg, the channel interfaces in rde_if.sv and row_distance_engine_top.
module row_distance_engine_top_tb;
   import rde_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 5;
   localparam int SETTLE_CYCLES = 8;          // margin for trailing load beats to retire
   localparam int RANDOM_BEATS  = 40;
   localparam int LIMIT_CYCLES  = 5_000_000;  // watchdog bound on the whole run
   localparam int ERROR_SHOWN   = 10;

   // csr index with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   localparam logic signed [VALUE_BITS-1:0] VALUE_TOP    = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic signed [VALUE_BITS-1:0] VALUE_BOTTOM = {1'b1, {(VALUE_BITS-1){1'b0}}};

   typedef struct packed {
      logic                         mode;
      logic        [ROW_W-1:0]      row_index;
      logic        [COL_W-1:0]      col_index;
      logic signed [VALUE_BITS-1:0] value;
   } element_beat_type;

   typedef struct packed {
      logic [ROW_W-1:0]  row_number;
      logic [DIST_W-1:0] distance;
      logic              last;
   } row_distance_type;

   logic clock = 1'b0;
   logic reset;

   rde_req_if req_ch ();
   rde_rsp_if rsp_ch ();
   rde_csr_if csr_ch ();

   row_distance_engine_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Predictor state: its own copy of the store, the query buffer and the registers.
   // The *_set flags track which entries were written, so no search touches an unwritten one.
   // ---------------------------------------------------------------------------------------
   logic signed [VALUE_BITS-1:0] train_mem [MAX_ROWS][MAX_COLS];
   bit                           train_set [MAX_ROWS][MAX_COLS];
   logic signed [VALUE_BITS-1:0] query_mem [MAX_COLS];
   bit                           query_set [MAX_COLS];
   logic                         cfg_metric;
   logic [ROWS_W-1:0]            cfg_rows;
   logic [COLS_W-1:0]            cfg_cols;

   row_distance_type awaited_distances [$];
   int unsigned      error_count;
   int unsigned      beats_sent;
   int unsigned      burst_left;

   // registers are clamped into 1..MAX when used
   function automatic int unsigned active_rows();
      if (cfg_rows == 0)
         return 1;
      return (cfg_rows > MAX_ROWS) ? MAX_ROWS : cfg_rows;
   endfunction

   function automatic int unsigned active_cols();
      if (cfg_cols == 0)
         return 1;
      return (cfg_cols > MAX_COLS) ? MAX_COLS : cfg_cols;
   endfunction

   // digit-by-digit floor square root; the sum of squares stays below 2^37
   function automatic longint unsigned floor_root(input longint unsigned x);
      longint unsigned root, trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= x)
            root = trial;
      end
      return root;
   endfunction

   function automatic logic [DIST_W-1:0] row_distance(input int unsigned r);
      longint unsigned total, mag, span;
      longint          delta;
      total = 0;
      for (int c = 0; c < active_cols(); c++) begin
         delta = longint'(query_mem[c]) - longint'(train_mem[r][c]);
         mag   = (delta < 0) ? -delta : delta;
         total += (cfg_metric == METRIC_MANHATTAN) ? mag : mag * mag;
      end
      span = (cfg_metric == METRIC_MANHATTAN) ? total : floor_root(total);
      if (span > DIST_MAX)
         span = DIST_MAX;
      return span[DIST_W-1:0];
   endfunction

   // update the copy of the engine for one accepted element; a query on the final column
   // queues one distance per active row
   function automatic void absorb_element(input element_beat_type beat);
      row_distance_type want;
      if (beat.mode == MODE_LOAD) begin
         train_mem[beat.row_index][beat.col_index] = beat.value;
         train_set[beat.row_index][beat.col_index] = 1'b1;
      end else begin
         query_mem[beat.col_index] = beat.value;
         query_set[beat.col_index] = 1'b1;
         if (beat.col_index == active_cols() - 1) begin
            for (int r = 0; r < active_rows(); r++) begin
               want.row_number = ROW_W'(r);
               want.distance   = row_distance(r);
               want.last       = (r == active_rows() - 1);
               awaited_distances.push_back(want);
            end
         end
      end
   endfunction

   // mostly uniform values, sometimes the edges of the Q8.8 range
   function automatic logic signed [VALUE_BITS-1:0] rand_value();
      case ($urandom_range(0, 11))
         0:       return VALUE_TOP;
         1:       return VALUE_BOTTOM;
         2:       return '0;
         3:       return '1;
         default: return VALUE_BITS'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------------------------------
   // Request side. The sender works in bursts; between most bursts valid drops for a gap.
   // valid only gets one nonblocking write per time step: a gap lowers it and waits on the
   // clock before it is raised again.
   // ---------------------------------------------------------------------------------------
   task automatic send_beat(input element_beat_type beat);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 10);
         if ($urandom_range(0, 3) != 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid     <= 1'b1;
      req_ch.mode      <= beat.mode;
      req_ch.row_index <= beat.row_index;
      req_ch.col_index <= beat.col_index;
      req_ch.value     <= beat.value;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      absorb_element(beat);
      beats_sent++;
   endtask

   task automatic send_load(input int unsigned row, input int unsigned col,
                            input logic signed [VALUE_BITS-1:0] value);
      element_beat_type beat;
      beat.mode      = MODE_LOAD;
      beat.row_index = ROW_W'(row);
      beat.col_index = COL_W'(col);
      beat.value     = value;
      send_beat(beat);
   endtask

   // row_index is don't-care on a query beat, so it carries random bits
   task automatic send_query(input int unsigned col, input logic signed [VALUE_BITS-1:0] value);
      element_beat_type beat;
      beat.mode      = MODE_QUERY;
      beat.row_index = ROW_W'($urandom_range(0, MAX_ROWS - 1));
      beat.col_index = COL_W'(col);
      beat.value     = value;
      send_beat(beat);
   endtask

   // write every store entry the next search reads that has not been written yet
   task automatic fill_store();
      for (int r = 0; r < active_rows(); r++)
         for (int c = 0; c < active_cols(); c++)
            if (!train_set[r][c])
               send_load(r, c, rand_value());
   endtask

   // a complete query: leading columns in shuffled order, stray load beats mixed in,
   // trigger column last
   task automatic send_query_row();
      int unsigned order [$];
      int unsigned last_col, pick, held;
      last_col = active_cols() - 1;
      for (int c = 0; c < last_col; c++)
         order.push_back(c);
      for (int i = order.size() - 1; i > 0; i--) begin
         pick        = $urandom_range(0, i);
         held        = order[i];
         order[i]    = order[pick];
         order[pick] = held;
      end
      foreach (order[i]) begin
         if ($urandom_range(0, 7) == 0)
            send_load($urandom_range(0, MAX_ROWS - 1), $urandom_range(0, MAX_COLS - 1),
                      rand_value());
         send_query(order[i], rand_value());
      end
      send_query(last_col, rand_value());
   endtask

   // drop valid, wait for every awaited distance, then let trailing load beats retire
   task automatic settle_engine();
      req_ch.valid <= 1'b0;
      while (awaited_distances.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // csr beat; valid is lowered and the task waits on the clock before returning, so
   // back-to-back writes never put two nonblocking writes on valid in one step
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] wdata);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= wdata;
      @(posedge clock);
      while (!csr_ch.ready)
         @(posedge clock);
      csr_ch.valid <= 1'b0;
      case (idx)
         CSR_METRIC: cfg_metric = wdata[0];
         CSR_ROWS:   cfg_rows   = wdata[ROWS_W-1:0];
         CSR_COLS:   cfg_cols   = wdata[COLS_W-1:0];
         default:    ;
      endcase
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // Response side. ready follows a rotating pattern: always ready, random one-in-three
   // stalls, random stall runs, and alternating ready and stall.
   // ---------------------------------------------------------------------------------------
   int unsigned rsp_cycle;
   int unsigned rsp_hold;

   initial begin
      rsp_ch.ready <= 1'b0;
      rsp_cycle = 0;
      rsp_hold  = 0;
      forever begin
         @(posedge clock);
         rsp_cycle++;
         case (rsp_cycle[9:8])
            2'd0: rsp_ch.ready <= 1'b1;
            2'd1: rsp_ch.ready <= ($urandom_range(0, 2) != 0);
            2'd2: begin
               if (rsp_hold != 0) begin
                  rsp_hold--;
                  rsp_ch.ready <= 1'b0;
               end else begin
                  rsp_ch.ready <= 1'b1;
                  if ($urandom_range(0, 7) == 0)
                     rsp_hold = $urandom_range(1, 20);
               end
            end
            default: rsp_ch.ready <= rsp_cycle[0];
         endcase
      end
   end

   // every accepted distance beat is matched against the oldest awaited one
   always @(posedge clock) begin : check_distance
      row_distance_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_distances.size() == 0) begin
            error_count++;
            if (error_count <= ERROR_SHOWN)
               $display("unexpected distance beat: row %0d distance %0d last %0b",
                        rsp_ch.row_number, rsp_ch.distance, rsp_ch.last);
         end else begin
            want = awaited_distances.pop_front();
            if (rsp_ch.row_number !== want.row_number || rsp_ch.distance !== want.distance ||
                rsp_ch.last !== want.last) begin
               error_count++;
               if (error_count <= ERROR_SHOWN)
                  $display({"distance mismatch: expected row %0d distance %0d last %0b,",
                            " got row %0d distance %0d last %0b"},
                           want.row_number, want.distance, want.last,
                           rsp_ch.row_number, rsp_ch.distance, rsp_ch.last);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // opposite range edges: largest per-column difference, and a row at distance zero,
   // under both metrics (the euclidean pass reuses the buffered query)
   task automatic test_value_extremes();
      settle_engine();
      csr_write(CSR_METRIC, CSR_DATA_W'(METRIC_MANHATTAN));
      csr_write(CSR_ROWS, 7'd2);
      csr_write(CSR_COLS, 7'd2);
      send_load(0, 0, VALUE_TOP);
      send_load(0, 1, VALUE_BOTTOM);
      send_load(1, 0, VALUE_BOTTOM);
      send_load(1, 1, VALUE_TOP);
      send_query(0, VALUE_BOTTOM);
      send_query(1, VALUE_TOP);
      settle_engine();
      csr_write(CSR_METRIC, CSR_DATA_W'(METRIC_EUCLIDEAN));
      send_query(1, VALUE_TOP);
   endtask

   // query beats off the trigger column, before it and past the end, only fill the buffer;
   // a second search after overwriting one buffered column
   task automatic test_query_columns();
      settle_engine();
      csr_write(CSR_METRIC, CSR_DATA_W'(METRIC_MANHATTAN));
      csr_write(CSR_ROWS, 7'd3);
      csr_write(CSR_COLS, 7'd3);
      fill_store();
      send_query(1, rand_value());
      send_query(9, rand_value());
      send_query(0, rand_value());
      send_query(2, rand_value());
      send_query(0, rand_value());
      send_query(2, rand_value());
   endtask

   // zero counts clamp to one; metric takes bit 0 only; the spare index changes nothing
   task automatic test_register_clamps();
      settle_engine();
      csr_write(CSR_ROWS, 7'd0);
      csr_write(CSR_COLS, 7'd0);
      csr_write(CSR_METRIC, 7'h7F);
      csr_write(CSR_SPARE, 7'h55);
      send_query(0, rand_value());
      settle_engine();
      csr_write(CSR_METRIC, 7'h7E);
      send_query(0, rand_value());
   endtask

   // all 16 columns on one row, then all 64 rows on one column: each first through the
   // clamp of an oversized register value, then at the exact maximum under the other metric
   task automatic test_full_size();
      settle_engine();
      csr_write(CSR_METRIC, CSR_DATA_W'(METRIC_MANHATTAN));
      csr_write(CSR_ROWS, 7'd1);
      csr_write(CSR_COLS, 7'd31);
      fill_store();
      send_query_row();
      settle_engine();
      csr_write(CSR_METRIC, CSR_DATA_W'(METRIC_EUCLIDEAN));
      csr_write(CSR_COLS, 7'(MAX_COLS));
      send_query(MAX_COLS - 1, rand_value());
      settle_engine();
      csr_write(CSR_METRIC, CSR_DATA_W'(METRIC_MANHATTAN));
      csr_write(CSR_ROWS, 7'd127);
      csr_write(CSR_COLS, 7'd1);
      fill_store();
      send_query_row();
      settle_engine();
      csr_write(CSR_METRIC, CSR_DATA_W'(METRIC_EUCLIDEAN));
      csr_write(CSR_ROWS, 7'(MAX_ROWS));
      send_query(0, rand_value());
   endtask

   // mostly well-formed searches with random content; some reconfiguration and noise beats.
   // Shapes are tall and narrow, short and wide, or small, so the store fill stays short.
   task automatic test_random_traffic();
      int unsigned stop_at, choice, col, last_col;
      logic [CSR_DATA_W-1:0] rows_w, cols_w;
      bit buffer_full;
      stop_at = beats_sent + RANDOM_BEATS;
      while (beats_sent < stop_at) begin
         choice = $urandom_range(0, 19);
         if (choice < 2) begin
            settle_engine();
            case ($urandom_range(0, 4))
               // tall and narrow: row count from 9 to past the top, one column
               0: begin
                  case ($urandom_range(0, 2))
                     0:       rows_w = 7'($urandom_range(MAX_ROWS + 1, 127));
                     1:       rows_w = 7'(MAX_ROWS);
                     default: rows_w = 7'($urandom_range(9, MAX_ROWS - 1));
                  endcase
                  cols_w = ($urandom_range(0, 1) != 0) ? 7'd0 : 7'd1;
               end
               // short and wide: column count from 5 to past the top, at most two rows
               1: begin
                  case ($urandom_range(0, 2))
                     0:       cols_w = 7'($urandom_range(MAX_COLS + 1, 31));
                     1:       cols_w = 7'(MAX_COLS);
                     default: cols_w = 7'($urandom_range(5, MAX_COLS - 1));
                  endcase
                  rows_w = 7'($urandom_range(0, 2));
               end
               default: begin
                  rows_w = 7'($urandom_range(0, 8));
                  cols_w = 7'($urandom_range(0, 4));
               end
            endcase
            if ($urandom_range(0, 2) != 0)
               csr_write(CSR_METRIC, 7'($urandom_range(0, 127)));
            csr_write(CSR_ROWS, rows_w);
            csr_write(CSR_COLS, cols_w);
         end else if (choice < 5) begin
            // noise: loads anywhere and query beats that never hit the trigger column
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 1) != 0) begin
                  send_load($urandom_range(0, MAX_ROWS - 1), $urandom_range(0, MAX_COLS - 1),
                            rand_value());
               end else begin
                  col = $urandom_range(0, MAX_COLS - 1);
                  if (col == active_cols() - 1)
                     col = (col + 1) % MAX_COLS;
                  send_query(col, rand_value());
               end
            end
         end else begin
            repeat ($urandom_range(0, 3))
               send_load($urandom_range(0, MAX_ROWS - 1), $urandom_range(0, MAX_COLS - 1),
                         rand_value());
            fill_store();
            last_col    = active_cols() - 1;
            buffer_full = 1'b1;
            for (int c = 0; c < last_col; c++)
               if (!query_set[c])
                  buffer_full = 1'b0;
            // a lone trigger beat searches with whatever the buffer holds
            if (buffer_full && $urandom_range(0, 3) == 0)
               send_query(last_col, rand_value());
            else
               send_query_row();
         end
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Sequence: reset once, directed tests, full size, random traffic, drain, verdict.
   // ---------------------------------------------------------------------------------------
   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.mode      <= MODE_LOAD;
      req_ch.row_index <= '0;
      req_ch.col_index <= '0;
      req_ch.value     <= '0;
      csr_ch.valid     <= 1'b0;
      csr_ch.index     <= CSR_METRIC;
      csr_ch.data      <= '0;
      cfg_metric  = METRIC_MANHATTAN;
      cfg_rows    = 7'(MAX_ROWS);
      cfg_cols    = 5'(MAX_COLS);
      error_count = 0;
      beats_sent  = 0;
      burst_left  = 0;
      foreach (train_set[r, c])
         train_set[r][c] = 1'b0;
      foreach (query_set[c])
         query_set[c] = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_value_extremes();
      test_query_columns();
      test_register_clamps();
      test_full_size();
      test_random_traffic();
      settle_engine();

      if (error_count == 0 && awaited_distances.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // watchdog: a hung handshake ends the run here
   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

endmodule
